FILE: hw/rtl/tst_pkg.sv
// Package with the flag bit positions, verdict codes and shared types of the stream tracker.
package tst_pkg;
	localparam int unsigned FLAG_ACK_BIT = 4;
	localparam int unsigned FLAG_RST_BIT = 2;
	localparam int unsigned FLAG_SYN_BIT = 1;
	localparam int unsigned FLAG_FIN_BIT = 0;

	typedef enum logic [3:0] {
		V_IN_ORDER     = 4'd0,
		V_RETRANSMIT   = 4'd1,
		V_GAP          = 4'd2,
		V_NO_HANDSHAKE = 4'd3,
		V_OPENED       = 4'd4,
		V_RESET        = 4'd5,
		V_FIN          = 4'd6,
		V_FIN_ORPHAN   = 4'd7,
		V_CLOSED       = 4'd8,
		V_FULL         = 4'd9
	} verdict_t;

	typedef struct packed {
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [31:0] sequence_req;
		logic [15:0] payload_bytes;
		logic [7:0]  tcp_flags;
	} segment_t;

	typedef struct packed {
		logic [3:0]  verdict;
		logic [31:0] retransmit_total;
		logic [31:0] gap_total;
	} result_t;

	// Key of one stream entry.
	typedef struct packed {
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] source_port;
		logic [15:0] dest_port;
	} stream_key_t;

	// Per-entry data kept in the flow RAM.
	typedef struct packed {
		logic [31:0] expected_sequence;
		logic        close_responder;
		logic        remove_on_ack;
	} stream_data_t;
endpackage

FILE: hw/rtl/tst_if.sv
// Valid/ready channel interfaces for segments and results.
interface tst_seg_if;
	logic               valid;
	logic               ready;
	tst_pkg::segment_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface tst_res_if;
	logic              valid;
	logic              ready;
	tst_pkg::result_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/tst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tst_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

FILE: hw/rtl/tst_match.sv
// Sequential key search: walks the key RAM one entry per cycle for a key.
module tst_match #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  tst_pkg::stream_key_t       key,
	input  logic [ENTRIES-1:0]         valid_bits,
	output logic [$clog2(ENTRIES)-1:0] rd_addr,
	input  tst_pkg::stream_key_t       rd_key,
	output logic                       done,
	output logic                       found,
	output logic [$clog2(ENTRIES)-1:0] index
);
	localparam int unsigned IW = $clog2(ENTRIES);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

	state_t        state_q;
	logic [IW:0]   addr_q;
	logic [IW-1:0] cmp_q;
	logic          cmp_live_q;
	logic          hit;
	logic          last_cmp;

	assign rd_addr = addr_q[IW-1:0];
	assign hit = cmp_live_q && valid_bits[cmp_q] && (rd_key == key);
	assign last_cmp = cmp_live_q && (cmp_q == IW'(ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			addr_q     <= '0;
			cmp_q      <= '0;
			cmp_live_q <= 1'b0;
			done       <= 1'b0;
			found      <= 1'b0;
			index      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					done <= 1'b0;
					if (start) begin
						addr_q     <= '0;
						cmp_live_q <= 1'b0;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					// Read data for address cmp_q arrives in the cycle after the request.
					cmp_q      <= addr_q[IW-1:0];
					cmp_live_q <= (addr_q < (IW+1)'(ENTRIES));
					if (addr_q < (IW+1)'(ENTRIES)) begin
						addr_q <= addr_q + 1'b1;
					end
					done <= hit || last_cmp;
					if (hit || last_cmp) begin
						found   <= hit;
						state_q <= S_DONE;
					end
					if (hit) begin
						index <= cmp_q;
					end
				end
				S_DONE: begin
					done    <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					done    <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

FILE: hw/rtl/tcp_stream_sequence_tracker.sv
// Top level of the TCP stream sequence tracker.
// Usage: one segment beat enters on seg; one result beat leaves on res for
// each segment, carrying the verdict and both running counters.
// Each segment takes a forward search of the key RAM, one entry per cycle,
// and for RST or FIN on a known stream a reverse search as well, then a
// read of the flow data and a write back where the flow data changes.
// One segment is handled at a time; seg.ready is high only while idle,
// which the tracker reaches through OUT after the result is registered.
// The result is held in an output register; the next segment is accepted
// while that result still waits, and a stalled receiver blocks only when a
// second result is ready before the first is taken.
// Reset clears the valid bits and both counters; the RAM contents stay
// undefined and are never used for an entry that is not valid.
// Free-slot choice uses the valid bits: the lowest free entry wins.
module tcp_stream_sequence_tracker #(
	parameter int unsigned STREAM_ENTRIES = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	tst_seg_if.sink   seg,
	tst_res_if.source res
);
	localparam int unsigned IW = $clog2(STREAM_ENTRIES);

	typedef enum logic [3:0] {
		S_IDLE, S_FWD, S_FWD_WAIT, S_REV, S_REV_WAIT, S_RD, S_RD_WAIT,
		S_EXEC, S_OUT
	} state_t;

	state_t                 state_q;
	tst_pkg::segment_t      seg_q;
	logic [STREAM_ENTRIES-1:0] valid_q;
	logic [31:0]            rtx_q;
	logic [31:0]            gap_q;
	logic                   s_found_q;
	logic [IW-1:0]          s_idx_q;
	logic                   r_found_q;
	logic [IW-1:0]          r_idx_q;
	logic                   out_valid_q;
	tst_pkg::result_t       out_q;

	// Search unit.
	logic                   m_start;
	tst_pkg::stream_key_t   m_key;
	logic [IW-1:0]          m_rd_addr;
	tst_pkg::stream_key_t   m_rd_key;
	logic                   m_done;
	logic                   m_found;
	logic [IW-1:0]          m_index;
	logic                   rev_q;

	// RAM ports.
	logic                   key_we;
	logic [IW-1:0]          key_waddr;
	tst_pkg::stream_key_t   key_wdata;
	logic                   dat_we;
	logic [IW-1:0]          dat_waddr;
	tst_pkg::stream_data_t  dat_wdata;
	logic [IW-1:0]          dat_raddr;
	tst_pkg::stream_data_t  dat_rdata;
	logic                   dat_aux_we;
	logic [IW-1:0]          dat_aux_addr;
	tst_pkg::stream_data_t  cur_data_q;
	logic                   dat_we_any;
	logic [IW-1:0]          dat_waddr_any;

	// Lowest free entry.
	logic                   free_found;
	logic [IW-1:0]          free_idx;

	tst_pkg::stream_key_t   fwd_key;
	tst_pkg::stream_key_t   rev_key;

	assign fwd_key = '{seg_q.source_address, seg_q.dest_address,
		seg_q.source_port, seg_q.dest_port};
	assign rev_key = '{seg_q.dest_address, seg_q.source_address,
		seg_q.dest_port, seg_q.source_port};
	assign m_key = rev_q ? rev_key : fwd_key;
	assign m_start = (state_q == S_FWD) || (state_q == S_REV);

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = STREAM_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	tst_match #(.ENTRIES(STREAM_ENTRIES)) u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (m_start),
		.key        (m_key),
		.valid_bits (valid_q),
		.rd_addr    (m_rd_addr),
		.rd_key     (m_rd_key),
		.done       (m_done),
		.found      (m_found),
		.index      (m_index)
	);

	tst_ram #(.WIDTH($bits(tst_pkg::stream_key_t)), .DEPTH(STREAM_ENTRIES)) u_key_ram (
		.clk     (clk),
		.wr_en   (key_we),
		.wr_addr (key_waddr),
		.wr_data (key_wdata),
		.rd_addr (m_rd_addr),
		.rd_data (m_rd_key)
	);

	tst_ram #(.WIDTH($bits(tst_pkg::stream_data_t)), .DEPTH(STREAM_ENTRIES)) u_dat_ram (
		.clk     (clk),
		.wr_en   (dat_we_any),
		.wr_addr (dat_waddr_any),
		.wr_data (dat_wdata),
		.rd_addr (dat_raddr),
		.rd_data (dat_rdata)
	);

	assign seg.ready = (state_q == S_IDLE);
	assign res.valid = out_valid_q;
	assign res.payload = out_q;

	// Execute-stage decode.
	logic                  f_syn, f_rst, f_fin, f_ack;
	logic [31:0]           seq_p1, seq_plen;
	tst_pkg::verdict_t     verdict;
	logic                  clr_s, clr_r, set_resp_r, inc_rtx, inc_gap;
	tst_pkg::stream_data_t new_s;

	assign f_syn = seg_q.tcp_flags[tst_pkg::FLAG_SYN_BIT];
	assign f_rst = seg_q.tcp_flags[tst_pkg::FLAG_RST_BIT];
	assign f_fin = seg_q.tcp_flags[tst_pkg::FLAG_FIN_BIT];
	assign f_ack = seg_q.tcp_flags[tst_pkg::FLAG_ACK_BIT];
	assign seq_p1 = seg_q.sequence_req + 32'd1;
	assign seq_plen = seg_q.sequence_req + {16'd0, seg_q.payload_bytes};

	always_comb begin
		verdict    = tst_pkg::V_NO_HANDSHAKE;
		clr_s      = 1'b0;
		clr_r      = 1'b0;
		set_resp_r = 1'b0;
		inc_rtx    = 1'b0;
		inc_gap    = 1'b0;
		new_s      = cur_data_q;
		key_we     = 1'b0;
		dat_we     = 1'b0;
		dat_waddr  = s_idx_q;
		key_waddr  = free_idx;
		key_wdata  = fwd_key;
		if (!s_found_q) begin
			if (f_syn && free_found) begin
				verdict   = tst_pkg::V_OPENED;
				key_we    = 1'b1;
				dat_we    = 1'b1;
				dat_waddr = free_idx;
				new_s     = '{seq_p1, 1'b0, 1'b0};
			end else if (f_syn) begin
				verdict = tst_pkg::V_FULL;
			end
		end else if (f_rst) begin
			verdict = tst_pkg::V_RESET;
			clr_s   = 1'b1;
			clr_r   = r_found_q;
		end else if (f_fin) begin
			dat_we = 1'b1;
			new_s.expected_sequence = seq_p1;
			if (cur_data_q.close_responder) begin
				clr_s   = 1'b1;
				verdict = tst_pkg::V_FIN;
			end else begin
				new_s.remove_on_ack = 1'b1;
				if (!r_found_q) begin
					clr_s   = 1'b1;
					verdict = tst_pkg::V_FIN_ORPHAN;
				end else begin
					set_resp_r = 1'b1;
					verdict    = tst_pkg::V_FIN;
					// Stream is its own reverse: both marks land on one entry.
					if (r_idx_q == s_idx_q) begin
						new_s.close_responder = 1'b1;
					end
				end
			end
		end else if (f_ack && cur_data_q.remove_on_ack) begin
			clr_s   = 1'b1;
			verdict = tst_pkg::V_CLOSED;
		end else if (seg_q.sequence_req < cur_data_q.expected_sequence) begin
			inc_rtx = 1'b1;
			verdict = tst_pkg::V_RETRANSMIT;
		end else begin
			dat_we = 1'b1;
			new_s.expected_sequence = seq_plen;
			if (seg_q.sequence_req > cur_data_q.expected_sequence) begin
				inc_gap = 1'b1;
				verdict = tst_pkg::V_GAP;
			end else begin
				verdict = tst_pkg::V_IN_ORDER;
			end
		end
		if (state_q != S_EXEC) begin
			key_we = 1'b0;
			dat_we = 1'b0;
		end
	end

	// Valid bits after this segment.
	logic [STREAM_ENTRIES-1:0] valid_next;
	always_comb begin
		valid_next = valid_q;
		if (verdict == tst_pkg::V_OPENED) begin
			valid_next[free_idx] = 1'b1;
		end
		if (clr_s) begin
			valid_next[s_idx_q] = 1'b0;
		end
		if (clr_r) begin
			valid_next[r_idx_q] = 1'b0;
		end
	end

	// The reverse entry's responder mark is set in a second write after a read.
	assign dat_aux_we   = (state_q == S_OUT) && set_resp_r && (r_idx_q != s_idx_q);
	assign dat_aux_addr = r_idx_q;

	tst_pkg::stream_data_t rev_wdata;
	always_comb begin
		rev_wdata = dat_rdata;
		rev_wdata.close_responder = 1'b1;
	end

	// Write port: the normal update in EXEC, the reverse mark in OUT.
	tst_pkg::stream_data_t dat_wdata_mux;
	assign dat_wdata_mux = dat_aux_we ? rev_wdata : new_s;

	always_comb begin
		dat_wdata = dat_wdata_mux;
	end

	assign dat_we_any    = dat_we || dat_aux_we;
	assign dat_waddr_any = dat_aux_we ? dat_aux_addr : dat_waddr;

	// Read address: forward entry in RD, reverse entry in EXEC for the OUT write.
	assign dat_raddr = (state_q == S_EXEC) ? r_idx_q : s_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seg_q       <= '0;
			valid_q     <= '0;
			rtx_q       <= '0;
			gap_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			rev_q       <= 1'b0;
			s_found_q   <= 1'b0;
			s_idx_q     <= '0;
			r_found_q   <= 1'b0;
			r_idx_q     <= '0;
			cur_data_q  <= '0;
		end else begin
			if (out_valid_q && res.ready && (state_q != S_EXEC)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (seg.valid) begin
						seg_q   <= seg.payload;
						rev_q   <= 1'b0;
						state_q <= S_FWD;
					end
				end
				S_FWD: state_q <= S_FWD_WAIT;
				S_FWD_WAIT: begin
					if (m_done) begin
						s_found_q <= m_found;
						s_idx_q   <= m_index;
						r_found_q <= 1'b0;
						if (m_found && (f_rst || f_fin)) begin
							rev_q   <= 1'b1;
							state_q <= S_REV;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_REV: state_q <= S_REV_WAIT;
				S_REV_WAIT: begin
					if (m_done) begin
						r_found_q <= m_found;
						r_idx_q   <= m_index;
						state_q   <= S_RD;
					end
				end
				S_RD: state_q <= S_RD_WAIT;
				S_RD_WAIT: begin
					cur_data_q <= dat_rdata;
					state_q    <= S_EXEC;
				end
				S_EXEC: begin
					// Wait for the previous result to drain before overwriting it.
					if (!out_valid_q || res.ready) begin
						valid_q                <= valid_next;
						out_q.verdict          <= verdict;
						out_q.retransmit_total <= rtx_q + {31'd0, inc_rtx};
						out_q.gap_total        <= gap_q + {31'd0, inc_gap};
						rtx_q                  <= rtx_q + {31'd0, inc_rtx};
						gap_q                  <= gap_q + {31'd0, inc_gap};
						out_valid_q            <= 1'b1;
						state_q                <= S_OUT;
					end
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
